FILE: design/pcws_pkg.sv
// Shared types, constants and codes for the priority credit work scheduler.
`default_nettype none

package pcws_pkg;

   // Worker count and field widths
   localparam int DEVICES     = 4;
   localparam int DEV_BITS    = 2;
   localparam int COUNT_BITS  = 16;
   localparam int SIZE_BITS   = 16;
   localparam int AMOUNT_BITS = 16;
   localparam int PRIO_BITS   = 8;
   localparam int ACT_BITS    = 3;
   localparam int KIND_BITS   = 2;
   localparam int ERR_BITS    = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 64;

   // Sum widths: one carry bit over the wider operand
   localparam int NEED_BITS = SIZE_BITS + 1;
   localparam int SUM_BITS  = AMOUNT_BITS + 1;

   localparam logic [COUNT_BITS-1:0] LOAD_MAX = {COUNT_BITS{1'b1}};

   // Register reset values
   localparam logic [ACT_BITS-1:0]        ACTIVE_RESET = ACT_BITS'(1);
   localparam logic [DEVICES*SIZE_BITS-1:0] BATCH_RESET  = 64'h0001_0001_0001_0001;
   localparam logic [DEVICES*SIZE_BITS-1:0] CAP_RESET    = 64'h0001_0001_0001_0001;
   localparam logic [DEVICES*PRIO_BITS-1:0] PRIO_RESET   = 32'h01_01_01_01;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE     = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_BATCH      = CSR_IDX_BITS'(1);
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAPACITY   = CSR_IDX_BITS'(2);
   localparam logic [CSR_IDX_BITS-1:0] CSR_PRIORITY   = CSR_IDX_BITS'(3);

   typedef enum logic [KIND_BITS-1:0] {
      KIND_SCHEDULE = 2'd0,
      KIND_DISPATCH = 2'd1,
      KIND_COMPLETE = 2'd2
   } kind_type;

   typedef enum logic [ERR_BITS-1:0] {
      ERR_OK        = 2'd0,
      ERR_UNKNOWN   = 2'd1,
      ERR_UNDERFLOW = 2'd2,
      ERR_SATURATED = 2'd3
   } err_type;

   typedef logic [DEVICES-1:0][COUNT_BITS-1:0] load_array_type;
   typedef logic [DEVICES-1:0][SIZE_BITS-1:0]  size_array_type;
   typedef logic [DEVICES-1:0][PRIO_BITS-1:0]  prio_array_type;

   // One input word as held in the input register
   typedef struct packed {
      kind_type                kind;
      logic [DEV_BITS-1:0]     device;
      logic [AMOUNT_BITS-1:0]  amount;
   } cmd_type;

   // Grant decision from the selector
   typedef struct packed {
      logic                  granted;
      logic [DEV_BITS-1:0]   device;
      logic [SIZE_BITS-1:0]  size;
   } grant_type;

endpackage

`default_nettype wire

FILE: design/pcws_select.sv
// Priority grant selection over the active workers that have room for a batch.
`default_nettype none

module pcws_select (
   input  wire pcws_pkg::load_array_type   loads,
   input  wire pcws_pkg::size_array_type   batch,
   input  wire pcws_pkg::size_array_type   capacity,
   input  wire pcws_pkg::prio_array_type   priority_level,
   input  wire logic [pcws_pkg::DEVICES-1:0] active_mask,
   output pcws_pkg::grant_type             grant
);
   import pcws_pkg::*;

   logic [DEVICES-1:0]   fits;
   logic [NEED_BITS-1:0] need [DEVICES];
   logic [PRIO_BITS-1:0] best_prio;

   // Fit check per worker: load plus batch must not pass capacity
   always_comb begin
      for (int i = 0; i < DEVICES; i++) begin
         need[i] = NEED_BITS'(loads[i]) + NEED_BITS'(batch[i]);
         fits[i] = active_mask[i] && (need[i] <= NEED_BITS'(capacity[i]));
      end
   end

   // Highest priority wins; strict compare keeps the lowest index on a tie
   always_comb begin
      grant     = '0;
      best_prio = '0;
      for (int i = 0; i < DEVICES; i++) begin
         if (fits[i] && (!grant.granted || priority_level[i] > best_prio)) begin
            grant.granted = 1'b1;
            grant.device  = DEV_BITS'(i);
            grant.size    = batch[i];
            best_prio     = priority_level[i];
         end
      end
   end

endmodule

`default_nettype wire

FILE: design/pcws_loads.sv
// Outstanding-load counters with dispatch and completion update and idle flag.
`default_nettype none

module pcws_loads (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire pcws_pkg::cmd_type             cmd,
   input  wire logic [pcws_pkg::DEVICES-1:0]  active_mask,
   output pcws_pkg::load_array_type           loads,
   output pcws_pkg::err_type                  err,
   output logic                               all_idle
);
   import pcws_pkg::*;

   load_array_type      load_ff;
   load_array_type      load_in;
   logic [COUNT_BITS-1:0] cur;
   logic [SUM_BITS-1:0]   sum;
   logic                  known;

   assign loads = load_ff;
   assign cur   = load_ff[cmd.device];
   assign sum   = SUM_BITS'(cur) + SUM_BITS'(cmd.amount);
   assign known = active_mask[cmd.device];

   // Load update for the word in flight
   always_comb begin
      load_in = load_ff;
      err     = ERR_OK;
      if (fire) begin
         case (cmd.kind)
            KIND_DISPATCH: begin
               if (!known) begin
                  err = ERR_UNKNOWN;
               end else if (sum > SUM_BITS'(LOAD_MAX)) begin
                  load_in[cmd.device] = LOAD_MAX;
                  err                 = ERR_SATURATED;
               end else begin
                  load_in[cmd.device] = COUNT_BITS'(sum);
               end
            end
            KIND_COMPLETE: begin
               if (!known) begin
                  err = ERR_UNKNOWN;
               end else if (SUM_BITS'(cmd.amount) > SUM_BITS'(cur)) begin
                  err = ERR_UNDERFLOW;
               end else begin
                  load_in[cmd.device] = COUNT_BITS'(SUM_BITS'(cur) - SUM_BITS'(cmd.amount));
               end
            end
            default: begin
               load_in = load_ff;
            end
         endcase
      end
   end

   // Idle after this step: every active load is zero
   always_comb begin
      all_idle = 1'b1;
      for (int i = 0; i < DEVICES; i++) begin
         if (active_mask[i] && load_in[i] != '0) begin
            all_idle = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= '0;
      end else begin
         load_ff <= load_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/priority_credit_work_scheduler.sv
// Top level: config registers, input register, grant/load logic, result register.
// A word passes the input register and then the result register before it shows on rsp_valid.
// Throughput: one word per cycle unless rsp_stall holds a full result register; the load
// counters update with the result register, so the next word already sees the new loads.
// Reset (synchronous, active high) clears all loads to zero, empties both stages and
// returns the registers to one worker, batch 1, capacity 1 and priority 1.
`default_nettype none

module priority_credit_work_scheduler (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [pcws_pkg::KIND_BITS-1:0]       req_kind,
   input  wire logic [pcws_pkg::DEV_BITS-1:0]        req_device,
   input  wire logic [pcws_pkg::AMOUNT_BITS-1:0]     req_amount,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_granted,
   output logic [pcws_pkg::DEV_BITS-1:0]             rsp_grant_device,
   output logic [pcws_pkg::SIZE_BITS-1:0]            rsp_grant_size,
   output logic [pcws_pkg::ERR_BITS-1:0]             rsp_error_code,
   output logic                                      rsp_all_idle,
   // configuration port
   input  wire logic                                 csr_write,
   input  wire logic [pcws_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [pcws_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import pcws_pkg::*;

   // Config registers
   logic [ACT_BITS-1:0]            active_ff;
   logic [DEVICES*SIZE_BITS-1:0]   batch_ff;
   logic [DEVICES*SIZE_BITS-1:0]   cap_ff;
   logic [DEVICES*PRIO_BITS-1:0]   prio_ff;

   // Input stage
   logic    s1_valid_ff, s1_valid_in;
   cmd_type s1_cmd_ff;

   // Result stage
   logic                  out_valid_ff, out_valid_in;
   logic                  out_granted_ff;
   logic [DEV_BITS-1:0]   out_device_ff;
   logic [SIZE_BITS-1:0]  out_size_ff;
   logic [ERR_BITS-1:0]   out_err_ff;
   logic                  out_idle_ff;

   logic                  advance;
   logic [ACT_BITS-1:0]   active_n;
   logic [DEVICES-1:0]    active_mask;
   load_array_type        loads;
   err_type               err;
   logic                  all_idle;
   grant_type             grant;
   logic                  is_schedule;

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         batch_ff  <= BATCH_RESET;
         cap_ff    <= CAP_RESET;
         prio_ff   <= PRIO_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_ACTIVE:   active_ff <= csr_wdata[ACT_BITS-1:0];
            CSR_BATCH:    batch_ff  <= csr_wdata[DEVICES*SIZE_BITS-1:0];
            CSR_CAPACITY: cap_ff    <= csr_wdata[DEVICES*SIZE_BITS-1:0];
            CSR_PRIORITY: prio_ff   <= csr_wdata[DEVICES*PRIO_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Active count clamps at DEVICES; mask marks workers in use
   always_comb begin
      active_n = (active_ff > ACT_BITS'(DEVICES)) ? ACT_BITS'(DEVICES) : active_ff;
      for (int i = 0; i < DEVICES; i++) begin
         active_mask[i] = ACT_BITS'(i) < active_n;
      end
   end

   // Handshake: input stage moves on when the result register is free or draining
   assign advance     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input word capture
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_cmd_ff.kind   <= kind_type'(req_kind);
         s1_cmd_ff.device <= req_device;
         s1_cmd_ff.amount <= req_amount;
      end
   end

   pcws_loads u_loads (
      .clock       (clock),
      .reset       (reset),
      .fire        (advance),
      .cmd         (s1_cmd_ff),
      .active_mask (active_mask),
      .loads       (loads),
      .err         (err),
      .all_idle    (all_idle)
   );

   pcws_select u_select (
      .loads          (loads),
      .batch          (batch_ff),
      .capacity       (cap_ff),
      .priority_level (prio_ff),
      .active_mask    (active_mask),
      .grant          (grant)
   );

   assign is_schedule = (s1_cmd_ff.kind == KIND_SCHEDULE);

   // Result word capture; grant fields only on a schedule
   always_ff @(posedge clock) begin
      if (advance) begin
         out_granted_ff <= is_schedule && grant.granted;
         out_device_ff  <= is_schedule ? grant.device : '0;
         out_size_ff    <= is_schedule ? grant.size : '0;
         out_err_ff     <= err;
         out_idle_ff    <= all_idle;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_granted      = out_granted_ff;
   assign rsp_grant_device = out_device_ff;
   assign rsp_grant_size   = out_size_ff;
   assign rsp_error_code   = out_err_ff;
   assign rsp_all_idle     = out_idle_ff;

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the priority credit work scheduler: scoreboard and drivers.
`timescale 1ns / 1ps

module testbench;
   import pcws_pkg::*;

   // One response word as the scheduler reports it
   typedef struct packed {
      logic                 granted;
      logic [DEV_BITS-1:0]  device;
      logic [SIZE_BITS-1:0] size;
      logic [ERR_BITS-1:0]  error;
      logic                 all_idle;
   } outcome_type;

   // Tracks worker loads and register settings, owes one outcome per accepted word
   class work_ledger;
      logic [ACT_BITS-1:0]              active;
      logic [DEVICES*SIZE_BITS-1:0]     batch;
      logic [DEVICES*SIZE_BITS-1:0]     capacity;
      logic [DEVICES*PRIO_BITS-1:0]     prio_levels;
      logic [COUNT_BITS-1:0]            load [DEVICES];
      outcome_type                      owed [$];
      outcome_type                      recent;
      int unsigned                      failures;

      function new();
         active      = ACTIVE_RESET;
         batch       = BATCH_RESET;
         capacity    = CAP_RESET;
         prio_levels = PRIO_RESET;
         foreach (load[i]) load[i] = '0;
         recent   = '0;
         failures = 0;
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_ACTIVE:   active      = data[ACT_BITS-1:0];
            CSR_BATCH:    batch       = data;
            CSR_CAPACITY: capacity    = data;
            CSR_PRIORITY: prio_levels = data[DEVICES*PRIO_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Counts above the worker total act as the worker total
      function int unsigned workers_in_use();
         return (active > DEVICES) ? DEVICES : active;
      endfunction

      // Apply one accepted word to the loads and queue the outcome it owes
      function void note_request(logic [KIND_BITS-1:0] kind, logic [DEV_BITS-1:0] device,
                                 logic [AMOUNT_BITS-1:0] amount);
         int unsigned         n;
         int unsigned         best;
         bit                  found;
         logic [NEED_BITS-1:0] need;
         logic [SUM_BITS-1:0]  sum;
         outcome_type         o;
         n     = workers_in_use();
         o     = '0;
         found = 0;
         best  = 0;
         if (kind == KIND_SCHEDULE) begin
            // strictly higher priority replaces, so ties keep the lowest index
            for (int i = 0; i < n; i++) begin
               need = NEED_BITS'(load[i]) + NEED_BITS'(batch[SIZE_BITS*i +: SIZE_BITS]);
               if (need <= NEED_BITS'(capacity[SIZE_BITS*i +: SIZE_BITS]) &&
                   (!found || prio_levels[PRIO_BITS*i +: PRIO_BITS] >
                              prio_levels[PRIO_BITS*best +: PRIO_BITS])) begin
                  found = 1;
                  best  = i;
               end
            end
            if (found) begin
               o.granted = 1'b1;
               o.device  = DEV_BITS'(best);
               o.size    = batch[SIZE_BITS*best +: SIZE_BITS];
            end
         end else if (kind == KIND_DISPATCH || kind == KIND_COMPLETE) begin
            if (device >= n) begin
               o.error = ERR_UNKNOWN;
            end else if (kind == KIND_DISPATCH) begin
               sum = SUM_BITS'(load[device]) + SUM_BITS'(amount);
               if (sum > SUM_BITS'(LOAD_MAX)) begin
                  load[device] = LOAD_MAX;
                  o.error      = ERR_SATURATED;
               end else begin
                  load[device] = sum[COUNT_BITS-1:0];
               end
            end else if (amount > load[device]) begin
               o.error = ERR_UNDERFLOW;
            end else begin
               load[device] = load[device] - amount;
            end
         end
         // idle flag covers active workers only
         o.all_idle = 1'b1;
         for (int i = 0; i < n; i++)
            if (load[i] != '0) o.all_idle = 1'b0;
         recent = o;
         owed.insert(owed.size(), o);
      endfunction

      function void report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         failures++;
      endfunction

      function void compare_field(string name, int unsigned got, int unsigned want);
         if (got != want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         if (owed.size() == 0) begin
            report($sformatf("response word %h with nothing outstanding", got));
            return;
         end
         want = owed.pop_front();
         compare_field("granted",      got.granted,  want.granted);
         compare_field("grant_device", got.device,   want.device);
         compare_field("grant_size",   got.size,     want.size);
         compare_field("error_code",   got.error,    want.error);
         compare_field("all_idle",     got.all_idle, want.all_idle);
      endfunction
   endclass

   // kind code the block leaves unused
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic [KIND_BITS-1:0]     req_kind         = '0;
   logic [DEV_BITS-1:0]      req_device       = '0;
   logic [AMOUNT_BITS-1:0]   req_amount       = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic                     rsp_granted;
   logic [DEV_BITS-1:0]      rsp_grant_device;
   logic [SIZE_BITS-1:0]     rsp_grant_size;
   logic [ERR_BITS-1:0]      rsp_error_code;
   logic                     rsp_all_idle;
   logic                     csr_write        = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index        = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata        = '0;

   bit          calm       = 1'b0;
   bit          hold_ask   = 1'b0;
   int unsigned words_sent = 0;
   work_ledger  ledger     = new();

   priority_credit_work_scheduler dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_device       (req_device),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_granted      (rsp_granted),
      .rsp_grant_device (rsp_grant_device),
      .rsp_grant_size   (rsp_grant_size),
      .rsp_error_code   (rsp_error_code),
      .rsp_all_idle     (rsp_all_idle),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Mostly small levels, with the extremes now and then
   function automatic logic [SIZE_BITS-1:0] pick_level(int unsigned top);
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return SIZE_BITS'($urandom_range(0, top));
      endcase
   endfunction

   // Offer one word, hold it until accepted, then log it; valid stays high
   task automatic send_word(logic [KIND_BITS-1:0] kind, logic [DEV_BITS-1:0] device,
                            logic [AMOUNT_BITS-1:0] amount);
      if (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 33);
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_device <= device;
      req_amount <= amount;
      do @(posedge clock); while (req_stall);
      ledger.note_request(kind, device, amount);
      if (kind != KIND_UNUSED) words_sent++;
   endtask

   // Drop valid and wait until every owed response has come back
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (ledger.owed.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_word(logic [CSR_IDX_BITS-1:0] index, logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      ledger.set_register(index, data);
   endtask

   // All four registers plus one write to an unmapped index
   task automatic program_registers(logic [ACT_BITS-1:0] act,
                                    logic [DEVICES*SIZE_BITS-1:0] batch,
                                    logic [DEVICES*SIZE_BITS-1:0] cap,
                                    logic [DEVICES*PRIO_BITS-1:0] prio);
      write_word(CSR_ACTIVE, CSR_DATA_BITS'(act));
      write_word(CSR_BATCH, batch);
      write_word(CSR_CAPACITY, cap);
      write_word(CSR_PRIORITY, CSR_DATA_BITS'(prio));
      write_word(CSR_IDX_BITS'(CSR_PRIORITY + 1 + $urandom_range(0, 3)), {$urandom, $urandom});
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Response side: check accepted words, random stall, one long hold-off
   initial begin : response_side
      int          hold_left;
      bit          hold_taken;
      outcome_type got;
      hold_left  = 0;
      hold_taken = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got = {rsp_granted, rsp_grant_device, rsp_grant_size, rsp_error_code, rsp_all_idle};
            ledger.check_result(got);
         end
         if (hold_ask && !hold_taken) begin
            hold_left  = 150;
            hold_taken = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 33);
         end
      end
   end

   // Request side: directed words, then random phases under varied settings
   initial begin : stimulus
      int unsigned                  phase_end;
      int unsigned                  pick;
      logic [DEV_BITS-1:0]          d;
      logic [AMOUNT_BITS-1:0]       amt;
      logic [ACT_BITS-1:0]          act;
      logic [DEVICES*SIZE_BITS-1:0] batch;
      logic [DEVICES*SIZE_BITS-1:0] cap;
      logic [DEVICES*PRIO_BITS-1:0] prio;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one worker, batch 1, capacity 1
      send_word(KIND_SCHEDULE, 2'd0, 16'h0000);
      send_word(KIND_DISPATCH, 2'd0, 16'h0001);
      send_word(KIND_SCHEDULE, 2'd3, 16'hFFFF);   // full, no grant
      send_word(KIND_COMPLETE, 2'd0, 16'h0002);   // more than the load
      send_word(KIND_COMPLETE, 2'd0, 16'h0001);
      send_word(KIND_DISPATCH, 2'd1, 16'h0005);   // worker not active
      send_word(KIND_COMPLETE, 2'd3, 16'h0000);
      send_word(KIND_UNUSED, 2'd3, 16'hFFFF);
      send_word(KIND_DISPATCH, 2'd0, 16'hFFFF);
      send_word(KIND_DISPATCH, 2'd0, 16'h0001);   // saturates
      send_word(KIND_COMPLETE, 2'd0, 16'hFFFF);
      finish_phase();

      // four workers, priority tie between 1 and 2
      program_registers(3'd4, 64'h0004_0004_0004_0004, '1, 32'h05_09_09_02);
      send_word(KIND_SCHEDULE, 2'd0, 16'h0000);
      send_word(KIND_DISPATCH, 2'd1, 16'hFFFF);
      send_word(KIND_SCHEDULE, 2'd0, 16'h0000);
      send_word(KIND_DISPATCH, 2'd3, 16'h0000);
      send_word(KIND_COMPLETE, 2'd1, 16'hFFFF);
      finish_phase();

      // no workers in use
      program_registers(3'd0, '1, '1, '0);
      send_word(KIND_SCHEDULE, 2'd0, 16'h0000);
      send_word(KIND_DISPATCH, 2'd0, 16'h0003);
      send_word(KIND_COMPLETE, 2'd2, 16'h0000);
      finish_phase();

      // count above the worker total, zero batch and zero capacity workers
      program_registers(3'd7, 64'h0000_FFFF_0003_0000, 64'h0000_FFFF_0002_0000,
                        32'hFF_00_FF_00);
      send_word(KIND_SCHEDULE, 2'd0, 16'h0000);
      send_word(KIND_DISPATCH, 2'd3, 16'h0001);
      send_word(KIND_SCHEDULE, 2'd0, 16'h0000);
      finish_phase();

      // random phases
      for (int phase = 0; words_sent < 1400; phase++) begin
         case ($urandom_range(0, 9))
            0:       act = '0;
            1:       act = ACT_BITS'($urandom_range(DEVICES + 1, 7));
            default: act = ACT_BITS'($urandom_range(1, DEVICES));
         endcase
         for (int i = 0; i < DEVICES; i++) begin
            batch[SIZE_BITS*i +: SIZE_BITS] = pick_level(8);
            cap[SIZE_BITS*i +: SIZE_BITS]   = pick_level(40);
         end
         prio = ($urandom_range(0, 4) == 0) ? {DEVICES{PRIO_BITS'($urandom)}} : $urandom;
         program_registers(act, batch, cap, prio);
         calm     = (phase == 1);
         hold_ask = (phase == 3);
         phase_end = words_sent + 175;
         while (words_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            d    = DEV_BITS'($urandom_range(0, DEVICES - 1));
            if (pick < 40) begin
               // schedule, then usually hand the grant its batch
               send_word(KIND_SCHEDULE, DEV_BITS'($urandom), AMOUNT_BITS'($urandom));
               if (ledger.recent.granted && $urandom_range(0, 99) < 85)
                  send_word(KIND_DISPATCH, ledger.recent.device, ledger.recent.size);
            end else if (pick < 70) begin
               case ($urandom_range(0, 9))
                  0:       amt = AMOUNT_BITS'(ledger.load[d] + 1);
                  1, 2:    amt = ledger.load[d];
                  default: amt = AMOUNT_BITS'($urandom_range(0, ledger.load[d]));
               endcase
               send_word(KIND_COMPLETE, d, amt);
            end else if (pick < 85) begin
               amt = ($urandom_range(0, 9) == 0) ? AMOUNT_BITS'($urandom)
                                                 : AMOUNT_BITS'($urandom_range(0, 20));
               send_word(KIND_DISPATCH, d, amt);
            end else begin
               send_word(KIND_BITS'($urandom), d, AMOUNT_BITS'($urandom));
            end
         end
         finish_phase();
         calm = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (ledger.failures == 0 && ledger.owed.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

FILE: sim.f
design/pcws_pkg.sv
design/pcws_select.sv
design/pcws_loads.sv
design/priority_credit_work_scheduler.sv
verif/testbench.sv
